// ===== src/byte_stream_hash32_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the byte stream hash blocks
// Concurrent property checks, sampled on the rising clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_HASH32_CORE_MACROS_SVH
`define BYTE_STREAM_HASH32_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define BSH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bsh32_pkg.sv =====
// ----------------------------------------------------------------------------
// bsh32_pkg
// Types, constants and mixing functions of the 32-bit byte stream hash.
// ----------------------------------------------------------------------------
package bsh32_pkg;

    localparam int LEN_BITS_DEF = 24;
    localparam int QUEUE_DEPTH  = 4;
    localparam int DATA_W       = 8;
    localparam int MSG_LEN_W    = 24;
    localparam int HASH_W       = 32;
    localparam int TAIL_W       = 24;

    typedef struct packed {
        logic [DATA_W-1:0]    data_byte;
        logic [MSG_LEN_W-1:0] msg_len;
        logic                 last_byte;
    } t_in_item;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic              len_mismatch;
    } t_out_item;

    // one request from the front to the back
    typedef struct packed {
        logic              first;     // use seed instead of running hash
        logic [HASH_W-1:0] seed;
        logic              group;     // run the main mixing step on word
        logic [HASH_W-1:0] word;
        logic              finish;    // tail mixing and avalanche follow
        logic              empty;     // empty message, result is zero
        logic [TAIL_W-1:0] tail;
        logic [1:0]        tail_cnt;
        logic              mismatch;
    } t_op;

    // finalization pipeline stage
    typedef struct packed {
        logic [HASH_W-1:0] h;
        logic [TAIL_W-1:0] tail;
        logic [1:0]        tail_cnt;
        logic              mismatch;
        logic              empty;
    } t_fin;

    function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
        sext8 = {{(HASH_W-8){b[7]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] group_mix(input logic [HASH_W-1:0] h_in,
                                                    input logic [HASH_W-1:0] word);
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] t;
        h = h_in + {16'h0, word[15:0]};
        t = ({16'h0, word[31:16]} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        group_mix = h;
    endfunction

    function automatic logic [HASH_W-1:0] tail_mix(input logic [HASH_W-1:0] h_in,
                                                   input logic [TAIL_W-1:0] tail,
                                                   input logic [1:0]        cnt);
        logic [HASH_W-1:0] h;
        h = h_in;
        case (cnt)
            2'd3: begin
                h = h + {16'h0, tail[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext8(tail[23:16]) << 18);
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + {16'h0, tail[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + sext8(tail[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        tail_mix = h;
    endfunction

    function automatic logic [HASH_W-1:0] aval_a(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        aval_a = h;
    endfunction

    function automatic logic [HASH_W-1:0] aval_b(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in ^ (h_in << 25);
        h = h + (h >> 6);
        aval_b = h;
    endfunction

endpackage

// ===== src/bsh32_front.sv =====
// ----------------------------------------------------------------------------
// bsh32_front
// Accepts message bytes, groups them by four, counts them and issues
// mixing and finish requests to the back end.
// ----------------------------------------------------------------------------
`include "byte_stream_hash32_core_macros.svh"

module bsh32_front #(
    parameter int LEN_BITS = bsh32_pkg::LEN_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bsh32_pkg::t_in_item i_item,
    input  logic                i_q_ready,
    output logic                o_push,
    output bsh32_pkg::t_op      o_op
);

    logic                r_in_msg;
    logic                n_in_msg;
    logic                r_seed_due;
    logic                n_seed_due;
    logic [31:0]         r_seed;
    logic [31:0]         n_seed;
    logic [23:0]         r_pend;
    logic [23:0]         n_pend;
    logic [1:0]          r_grp;
    logic [1:0]          n_grp;
    logic [LEN_BITS-1:0] r_total;
    logic [LEN_BITS-1:0] n_total;

    logic [31:0]         len_ext;
    logic [LEN_BITS-1:0] len;
    logic                len_zero;
    logic                accept;
    logic                start;
    logic [23:0]         pend;
    logic [1:0]          grp;
    logic [LEN_BITS-1:0] total;

    assign len_ext  = 32'(i_item.msg_len);
    assign len      = len_ext[LEN_BITS-1:0];
    assign len_zero = (len == '0);
    assign o_ready  = i_q_ready;
    assign accept   = i_valid && o_ready;
    assign start    = !r_in_msg;
    assign pend     = start ? 24'h0 : r_pend;
    assign grp      = start ? 2'd0 : r_grp;
    assign total    = start ? '0 : r_total;

    always_comb begin
        n_in_msg   = r_in_msg;
        n_seed_due = r_seed_due;
        n_seed     = r_seed;
        n_pend     = r_pend;
        n_grp      = r_grp;
        n_total    = r_total;
        o_push     = 1'b0;
        o_op       = '0;
        o_op.seed  = start ? 32'(len) : r_seed;
        o_op.first = start || r_seed_due;

        if (accept) begin
            if (len_zero) begin
                // empty message: drop whatever was in progress
                o_push     = 1'b1;
                o_op.empty = 1'b1;
                o_op.first = 1'b0;
                n_in_msg   = 1'b0;
                n_seed_due = 1'b0;
                n_pend     = 24'h0;
                n_grp      = 2'd0;
                n_total    = '0;
            end else begin
                n_in_msg = 1'b1;
                n_seed   = o_op.seed;
                n_total  = (total == '1) ? total : total + LEN_BITS'(1);
                case (grp)
                    2'd0: begin
                        n_pend = {16'h0, i_item.data_byte};
                        n_grp  = 2'd1;
                    end
                    2'd1: begin
                        n_pend = {8'h0, i_item.data_byte, pend[7:0]};
                        n_grp  = 2'd2;
                    end
                    2'd2: begin
                        n_pend = {i_item.data_byte, pend[15:0]};
                        n_grp  = 2'd3;
                    end
                    default: begin
                        o_op.group = 1'b1;
                        o_op.word  = {i_item.data_byte, pend};
                        n_pend     = 24'h0;
                        n_grp      = 2'd0;
                    end
                endcase

                o_op.finish   = i_item.last_byte;
                o_op.tail     = n_pend;
                o_op.tail_cnt = n_grp;
                o_op.mismatch = (n_total != len);
                o_push        = o_op.group || i_item.last_byte;

                // hold the seed until the first request of the message goes out
                n_seed_due = o_push ? 1'b0 : o_op.first;

                if (i_item.last_byte) begin
                    n_in_msg   = 1'b0;
                    n_seed_due = 1'b0;
                    n_pend     = 24'h0;
                    n_grp      = 2'd0;
                    n_total    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg   <= 1'b0;
            r_seed_due <= 1'b0;
            r_pend     <= 24'h0;
            r_grp      <= 2'd0;
            r_total    <= '0;
        end else begin
            r_in_msg   <= n_in_msg;
            r_seed_due <= n_seed_due;
            r_pend     <= n_pend;
            r_grp      <= n_grp;
            r_total    <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed <= n_seed;
    end

    `BSH_ASSERT_NEXT(a_end_goes_idle, i_clk, i_rst_n, accept && (len_zero || i_item.last_byte), !r_in_msg, "front still in a message after its end")

endmodule

// ===== src/bsh32_queue.sv =====
// ----------------------------------------------------------------------------
// bsh32_queue
// Short request queue between front and back end.
// ----------------------------------------------------------------------------
`include "byte_stream_hash32_core_macros.svh"

module bsh32_queue #(
    parameter int DEPTH = bsh32_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsh32_pkg::t_op i_op,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output bsh32_pkg::t_op o_op
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bsh32_pkg::t_op r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  n_wr;
    logic [AW-1:0]  r_rd;
    logic [AW-1:0]  n_rd;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    `BSH_ASSERT_SAME(a_no_overfill, i_clk, i_rst_n, i_push, r_count != CW'(DEPTH), "request pushed into a full queue")
    `BSH_ASSERT_SAME(a_no_underrun, i_clk, i_rst_n, i_pop, r_count != '0, "request popped from an empty queue")

endmodule

// ===== src/bsh32_back.sv =====
// ----------------------------------------------------------------------------
// bsh32_back
// Runs the main mixing step on the running hash and carries finished
// messages through tail mixing and avalanche into the output register.
// ----------------------------------------------------------------------------
`include "byte_stream_hash32_core_macros.svh"

module bsh32_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  bsh32_pkg::t_op       i_op,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output bsh32_pkg::t_out_item o_item
);

    logic [31:0]          r_acc;
    logic                 r_p1_vld;
    logic                 r_p2_vld;
    logic                 r_p3_vld;
    logic                 r_out_vld;
    bsh32_pkg::t_fin      r_p1;
    bsh32_pkg::t_fin      r_p2;
    bsh32_pkg::t_fin      r_p3;
    bsh32_pkg::t_out_item r_out;

    bsh32_pkg::t_fin      n_p1;
    bsh32_pkg::t_fin      n_p2;
    bsh32_pkg::t_fin      n_p3;
    bsh32_pkg::t_out_item n_out;

    logic                 en;
    logic [31:0]          base;
    logic [31:0]          mixed;

    // advance the whole pipeline unless a finished result is held
    assign en    = !r_out_vld || i_ready;
    assign o_pop = en && i_op_valid;
    assign base  = i_op.first ? i_op.seed : r_acc;
    assign mixed = i_op.group ? bsh32_pkg::group_mix(base, i_op.word) : base;

    always_comb begin
        n_p1          = '0;
        n_p1.h        = mixed;
        n_p1.tail     = i_op.tail;
        n_p1.tail_cnt = i_op.tail_cnt;
        n_p1.mismatch = i_op.mismatch;
        n_p1.empty    = i_op.empty;

        n_p2   = r_p1;
        n_p2.h = bsh32_pkg::tail_mix(r_p1.h, r_p1.tail, r_p1.tail_cnt);

        n_p3   = r_p2;
        n_p3.h = bsh32_pkg::aval_a(r_p2.h);

        n_out.hash_value   = r_p3.empty ? 32'h0 : bsh32_pkg::aval_b(r_p3.h);
        n_out.len_mismatch = r_p3.mismatch && !r_p3.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld  <= o_pop && (i_op.finish || i_op.empty);
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_out_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_op.empty) begin
            r_acc <= mixed;
        end
        if (en) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    `BSH_ASSERT_NEXT(a_finish_enters, i_clk, i_rst_n, o_pop && (i_op.finish || i_op.empty), r_p1_vld, "finish request lost at pipeline entry")

endmodule

// ===== src/byte_stream_hash32_core.sv =====
// ----------------------------------------------------------------------------
// byte_stream_hash32_core
// 32-bit SuperFastHash of a byte message streamed in one byte per request.
//
//   channel  dir   handshake                  payload
//   in       in    i_in_valid / o_in_ready    i_in_data  (byte, length, last)
//   out      out   o_out_valid / i_out_ready  o_out_data (hash, length mismatch)
//
// One byte is taken every cycle while the request queue has room; the front issues
// at most one request per byte. The result of a last byte (or empty message) is
// set by the tail and two avalanche stages behind the running-hash register.
// While the output is stalled the request queue absorbs up to QUEUE_DEPTH
// group or finish requests; o_in_ready drops only once it is full.
// Reset is synchronous and clears control state only; no clearing pass.
// ----------------------------------------------------------------------------
module byte_stream_hash32_core #(
    parameter int LEN_BITS    = bsh32_pkg::LEN_BITS_DEF,
    parameter int QUEUE_DEPTH = bsh32_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bsh32_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bsh32_pkg::t_out_item o_out_data
);

    logic           q_ready;
    logic           push;
    bsh32_pkg::t_op push_op;
    logic           q_valid;
    logic           pop;
    bsh32_pkg::t_op pop_op;

    bsh32_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in_data),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_op      (push_op)
    );

    bsh32_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (pop_op)
    );

    bsh32_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (pop_op),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_data)
    );

endmodule
